>>> hw/rtl/clipped_alpha_sprite_blitter_defines.svh
`ifndef CLIPPED_ALPHA_SPRITE_BLITTER_DEFINES_SVH
`define CLIPPED_ALPHA_SPRITE_BLITTER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define CASB_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define CASB_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

>>> hw/rtl/casb_pkg.sv
package casb_pkg;

   localparam int PANEL_WIDTH_DEFAULT  = 32;
   localparam int PANEL_HEIGHT_DEFAULT = 8;

   localparam int CMD_W      = 2;
   localparam int CHAN_W     = 8;
   localparam int COL_W      = 5;
   localparam int ROW_W      = 3;
   localparam int WORD_W     = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int PROD_W     = 16;

   typedef enum logic [CMD_W-1:0] {
      CMD_FILL    = 2'd0,
      CMD_PIXEL   = 2'd1,
      CMD_READ    = 2'd2,
      CMD_RESTART = 2'd3
   } cmd_type;

   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPRITE_W   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPRITE_H   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BACKGROUND = 3'd4;

   typedef enum logic [2:0] {
      EMIT_NONE,
      EMIT_FILL,
      EMIT_PIXEL,
      EMIT_READ,
      EMIT_ZERO
   } emit_type;

   typedef struct packed {
      logic     capture;
      logic     fill_step;
      logic     addr_calc;
      logic     mem_read;
      logic     mul;
      emit_type emit;
   } dp_ctrl_type;

   typedef struct packed {
      logic in_panel;
      logic fill_last;
   } dp_status_type;

   // Exact floor(x / 255) for any 16-bit x below 65280, where the quotient fits in 8 bits.
   function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
      logic [PROD_W:0] t;
      t = {1'b0, x} + {9'd0, x[PROD_W-1:CHAN_W]} + 17'd1;
      return t[PROD_W-1:CHAN_W];
   endfunction

endpackage

>>> hw/rtl/clipped_alpha_sprite_blitter.sv
// Alpha-over sprite blitter with a PANEL_WIDTH x PANEL_HEIGHT framebuffer of 32-bit pixels in
// a single-port-write, registered-read RAM. A request is taken when start is high and busy is
// low; exactly one response follows, shown for one cycle with rsp_strobe, and it cannot be
// held off, so capture it on that cycle. The strobe cycle already accepts the next request.
// From acceptance, a visible sprite pixel steps through address, RAM read, multiply, and
// blend and write back; a clipped pixel skips the RAM read and multiply; a read takes address
// and RAM read (only address outside the panel); a raster restart just responds; and a fill
// writes one pixel a cycle through the RAM's write port. Reading a pixel before any fill
// returns undefined data. Configuration writes must be made while busy is low.
`include "clipped_alpha_sprite_blitter_defines.svh"

module clipped_alpha_sprite_blitter #(
   parameter int PANEL_WIDTH  = casb_pkg::PANEL_WIDTH_DEFAULT,
   parameter int PANEL_HEIGHT = casb_pkg::PANEL_HEIGHT_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [casb_pkg::CMD_W-1:0]        req_cmd,
   input  logic [casb_pkg::CHAN_W-1:0]       req_red,
   input  logic [casb_pkg::CHAN_W-1:0]       req_green,
   input  logic [casb_pkg::CHAN_W-1:0]       req_blue,
   input  logic [casb_pkg::CHAN_W-1:0]       req_alpha,
   input  logic [casb_pkg::COL_W-1:0]        req_read_col,
   input  logic [casb_pkg::ROW_W-1:0]        req_read_row,
   output logic                              rsp_strobe,
   output logic [casb_pkg::CHAN_W-1:0]       rsp_out_red,
   output logic [casb_pkg::CHAN_W-1:0]       rsp_out_green,
   output logic [casb_pkg::CHAN_W-1:0]       rsp_out_blue,
   output logic [casb_pkg::CHAN_W-1:0]       rsp_out_alpha,
   output logic                              rsp_landed,
   output logic                              rsp_sprite_done,
   input  logic                              csr_write_en,
   input  logic [casb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [casb_pkg::WORD_W-1:0]       csr_wdata
);
   import casb_pkg::*;

   dp_ctrl_type   ctrl;
   dp_status_type status;

   casb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_cmd    (req_cmd),
      .status     (status),
      .ctrl       (ctrl),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   casb_datapath #(
      .PANEL_WIDTH  (PANEL_WIDTH),
      .PANEL_HEIGHT (PANEL_HEIGHT)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_cmd         (req_cmd),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .req_alpha       (req_alpha),
      .req_read_col    (req_read_col),
      .req_read_row    (req_read_row),
      .ctrl            (ctrl),
      .status          (status),
      .rsp_out_red     (rsp_out_red),
      .rsp_out_green   (rsp_out_green),
      .rsp_out_blue    (rsp_out_blue),
      .rsp_out_alpha   (rsp_out_alpha),
      .rsp_landed      (rsp_landed),
      .rsp_sprite_done (rsp_sprite_done)
   );

   `CASB_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy)
   `CASB_ASSERT_IMP(a_strobe_idle, clock, reset, rsp_strobe, !busy)
   `CASB_ASSERT_IMP(a_strobe_after_work, clock, reset, rsp_strobe, $past(busy))

endmodule

>>> hw/rtl/casb_ram.sv
module casb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                                   clock,
   input  logic                                   write_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] write_addr,
   input  logic [WIDTH-1:0]                       write_data,
   input  logic                                   read_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] read_addr,
   output logic [WIDTH-1:0]                       read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
      if (read_en) begin
         read_data_ff <= mem_ff[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

>>> hw/rtl/casb_ctrl.sv
module casb_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [casb_pkg::CMD_W-1:0]    req_cmd,
   input  casb_pkg::dp_status_type       status,
   output casb_pkg::dp_ctrl_type         ctrl,
   output logic                          busy,
   output logic                          rsp_strobe
);
   import casb_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_ADDR,
      ST_MEM_RD,
      ST_MUL,
      ST_PIX_WR,
      ST_RD_OUT,
      ST_ZERO_OUT
   } state_type;

   state_type state_ff, state_in;
   cmd_type   cmd_ff, cmd_in;
   logic      strobe_ff, strobe_in;

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      ctrl     = '{capture: 1'b0, fill_step: 1'b0, addr_calc: 1'b0,
                   mem_read: 1'b0, mul: 1'b0, emit: EMIT_NONE};
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ctrl.capture = 1'b1;
               cmd_in       = cmd_type'(req_cmd);
               case (cmd_type'(req_cmd))
                  CMD_FILL:  state_in = ST_FILL;
                  CMD_PIXEL: state_in = ST_ADDR;
                  CMD_READ:  state_in = ST_ADDR;
                  default:   state_in = ST_ZERO_OUT;
               endcase
            end
         end
         ST_FILL: begin
            ctrl.fill_step = 1'b1;
            if (status.fill_last) begin
               ctrl.emit = EMIT_FILL;
               state_in  = ST_IDLE;
            end
         end
         ST_ADDR: begin
            ctrl.addr_calc = 1'b1;
            if (status.in_panel) begin
               state_in = ST_MEM_RD;
            end else if (cmd_ff == CMD_PIXEL) begin
               state_in = ST_PIX_WR;
            end else begin
               state_in = ST_ZERO_OUT;
            end
         end
         ST_MEM_RD: begin
            ctrl.mem_read = 1'b1;
            state_in = (cmd_ff == CMD_PIXEL) ? ST_MUL : ST_RD_OUT;
         end
         ST_MUL: begin
            ctrl.mul = 1'b1;
            state_in = ST_PIX_WR;
         end
         ST_PIX_WR: begin
            ctrl.emit = EMIT_PIXEL;
            state_in  = ST_IDLE;
         end
         ST_RD_OUT: begin
            ctrl.emit = EMIT_READ;
            state_in  = ST_IDLE;
         end
         ST_ZERO_OUT: begin
            ctrl.emit = EMIT_ZERO;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      strobe_in = (ctrl.emit != EMIT_NONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cmd_ff    <= CMD_FILL;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cmd_ff    <= cmd_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;

endmodule

>>> hw/rtl/casb_datapath.sv
module casb_datapath #(
   parameter int PANEL_WIDTH  = casb_pkg::PANEL_WIDTH_DEFAULT,
   parameter int PANEL_HEIGHT = casb_pkg::PANEL_HEIGHT_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [casb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [casb_pkg::WORD_W-1:0]       csr_wdata,
   input  logic [casb_pkg::CMD_W-1:0]        req_cmd,
   input  logic [casb_pkg::CHAN_W-1:0]       req_red,
   input  logic [casb_pkg::CHAN_W-1:0]       req_green,
   input  logic [casb_pkg::CHAN_W-1:0]       req_blue,
   input  logic [casb_pkg::CHAN_W-1:0]       req_alpha,
   input  logic [casb_pkg::COL_W-1:0]        req_read_col,
   input  logic [casb_pkg::ROW_W-1:0]        req_read_row,
   input  casb_pkg::dp_ctrl_type             ctrl,
   output casb_pkg::dp_status_type           status,
   output logic [casb_pkg::CHAN_W-1:0]       rsp_out_red,
   output logic [casb_pkg::CHAN_W-1:0]       rsp_out_green,
   output logic [casb_pkg::CHAN_W-1:0]       rsp_out_blue,
   output logic [casb_pkg::CHAN_W-1:0]       rsp_out_alpha,
   output logic                              rsp_landed,
   output logic                              rsp_sprite_done
);
   import casb_pkg::*;

   localparam int DEPTH  = PANEL_WIDTH * PANEL_HEIGHT;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int POS_W  = 10;
   localparam int LIN_W  = 18;

   logic [CHAN_W-1:0] origin_x_ff, origin_y_ff, sprite_w_ff, sprite_h_ff;
   logic [WORD_W-1:0] background_ff;
   logic [CHAN_W-1:0] raster_col_ff, raster_row_ff;

   logic [CHAN_W-1:0] src_r_ff, src_g_ff, src_b_ff, src_a_ff;
   logic [POS_W-1:0]  px_ff, py_ff, px_in, py_in;
   logic [ADDR_W-1:0] addr_ff, fill_cnt_ff;
   logic              in_panel_ff;
   logic [LIN_W-1:0]  lin_addr;
   logic              in_panel;

   logic [PROD_W-1:0] prod_r_ff, prod_g_ff, prod_b_ff;
   logic [CHAN_W-1:0] dst_a_ff;
   logic [CHAN_W-1:0] inv_a;
   logic [WORD_W-1:0] ram_rdata;
   logic [WORD_W-1:0] blend_word;
   logic              col_last, row_last;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [WORD_W-1:0] ram_wdata;

   logic [WORD_W-1:0] out_word_ff, out_word_in;
   logic              landed_ff, landed_in, done_ff, done_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff   <= '0;
         origin_y_ff   <= '0;
         sprite_w_ff   <= 8'd8;
         sprite_h_ff   <= 8'd8;
         background_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_ORIGIN_X:   origin_x_ff   <= csr_wdata[CHAN_W-1:0];
            CSR_ORIGIN_Y:   origin_y_ff   <= csr_wdata[CHAN_W-1:0];
            CSR_SPRITE_W:   sprite_w_ff   <= csr_wdata[CHAN_W-1:0];
            CSR_SPRITE_H:   sprite_h_ff   <= csr_wdata[CHAN_W-1:0];
            CSR_BACKGROUND: background_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (cmd_type'(req_cmd) == CMD_READ) begin
         px_in = {{(POS_W - COL_W){1'b0}}, req_read_col};
         py_in = {{(POS_W - ROW_W){1'b0}}, req_read_row};
      end else begin
         px_in = {{2{origin_x_ff[CHAN_W-1]}}, origin_x_ff} + {2'b00, raster_col_ff};
         py_in = {{2{origin_y_ff[CHAN_W-1]}}, origin_y_ff} + {2'b00, raster_row_ff};
      end
   end

   assign in_panel = !px_ff[POS_W-1] && (px_ff[POS_W-2:0] < 9'(PANEL_WIDTH))
                  && !py_ff[POS_W-1] && (py_ff[POS_W-2:0] < 9'(PANEL_HEIGHT));
   assign lin_addr = LIN_W'(py_ff[POS_W-2:0]) * LIN_W'(PANEL_WIDTH)
                   + LIN_W'(px_ff[POS_W-2:0]);

   assign status.in_panel  = in_panel;
   assign status.fill_last = (fill_cnt_ff == ADDR_W'(DEPTH - 1));

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         src_r_ff <= req_red;
         src_g_ff <= req_green;
         src_b_ff <= req_blue;
         src_a_ff <= req_alpha;
         px_ff    <= px_in;
         py_ff    <= py_in;
      end
      if (ctrl.addr_calc) begin
         addr_ff     <= lin_addr[ADDR_W-1:0];
         in_panel_ff <= in_panel;
      end
      if (ctrl.mul) begin
         prod_r_ff <= inv_a * ram_rdata[31:24];
         prod_g_ff <= inv_a * ram_rdata[23:16];
         prod_b_ff <= inv_a * ram_rdata[15:8];
         dst_a_ff  <= ram_rdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_cnt_ff <= '0;
      end else if (ctrl.capture) begin
         fill_cnt_ff <= '0;
      end else if (ctrl.fill_step) begin
         fill_cnt_ff <= fill_cnt_ff + ADDR_W'(1);
      end
   end

   assign inv_a = 8'd255 - src_a_ff;

   assign blend_word = {src_r_ff + div255(prod_r_ff),
                        src_g_ff + div255(prod_g_ff),
                        src_b_ff + div255(prod_b_ff),
                        dst_a_ff};

   assign col_last = ({1'b0, raster_col_ff} + 9'd1) >= {1'b0, sprite_w_ff};
   assign row_last = ({1'b0, raster_row_ff} + 9'd1) >= {1'b0, sprite_h_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         raster_col_ff <= '0;
         raster_row_ff <= '0;
      end else if (ctrl.capture && cmd_type'(req_cmd) == CMD_RESTART) begin
         raster_col_ff <= '0;
         raster_row_ff <= '0;
      end else if (ctrl.emit == EMIT_PIXEL) begin
         if (col_last) begin
            raster_col_ff <= '0;
            raster_row_ff <= row_last ? '0 : raster_row_ff + 8'd1;
         end else begin
            raster_col_ff <= raster_col_ff + 8'd1;
         end
      end
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = addr_ff;
      ram_wdata = blend_word;
      if (ctrl.fill_step) begin
         ram_we    = 1'b1;
         ram_waddr = fill_cnt_ff;
         ram_wdata = background_ff;
      end else if (ctrl.emit == EMIT_PIXEL && in_panel_ff) begin
         ram_we = 1'b1;
      end
   end

   casb_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_frame_store (
      .clock      (clock),
      .write_en   (ram_we),
      .write_addr (ram_waddr),
      .write_data (ram_wdata),
      .read_en    (ctrl.mem_read),
      .read_addr  (addr_ff),
      .read_data  (ram_rdata)
   );

   always_comb begin
      out_word_in = out_word_ff;
      landed_in   = landed_ff;
      done_in     = done_ff;
      case (ctrl.emit)
         EMIT_FILL: begin
            out_word_in = background_ff;
            landed_in   = 1'b0;
            done_in     = 1'b0;
         end
         EMIT_PIXEL: begin
            out_word_in = in_panel_ff ? blend_word : '0;
            landed_in   = in_panel_ff;
            done_in     = col_last && row_last;
         end
         EMIT_READ: begin
            out_word_in = ram_rdata;
            landed_in   = 1'b0;
            done_in     = 1'b0;
         end
         EMIT_ZERO: begin
            out_word_in = '0;
            landed_in   = 1'b0;
            done_in     = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      out_word_ff <= out_word_in;
      landed_ff   <= landed_in;
      done_ff     <= done_in;
   end

   assign rsp_out_red     = out_word_ff[31:24];
   assign rsp_out_green   = out_word_ff[23:16];
   assign rsp_out_blue    = out_word_ff[15:8];
   assign rsp_out_alpha   = out_word_ff[7:0];
   assign rsp_landed      = landed_ff;
   assign rsp_sprite_done = done_ff;

endmodule
